// ===== rtl/core/exposure_countdown_timer_assert.svh =====
// Assertion macros for the exposure countdown timer checker.
// Self-contained; expects clk and arst_n in the scope where a macro is used.
`ifndef EXPOSURE_COUNTDOWN_TIMER_ASSERT_SVH
`define EXPOSURE_COUNTDOWN_TIMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ECT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ect assertion failed");

// next-cycle implication, disabled in reset
`define ECT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ect assertion failed");

`endif

// ===== rtl/core/ect_pkg.sv =====
// Shared types and constants for the exposure countdown timer.
// No dependencies.
package ect_pkg;

	localparam logic [5:0] TIME_MAX   = 6'd59;
	localparam logic [5:0] FINISH_LEN = 6'd40;

	// end-phase digit glyphs
	localparam logic [3:0] END_D1 = 4'd11;
	localparam logic [3:0] END_D2 = 4'd12;
	localparam logic [3:0] END_D3 = 4'd13;

	// beeper on windows within the end phase
	localparam logic [5:0] BEEP1_END = 6'd10;
	localparam logic [5:0] BEEP2_BEG = 6'd13;
	localparam logic [5:0] BEEP2_END = 6'd23;
	localparam logic [5:0] BEEP3_BEG = 6'd26;
	localparam logic [5:0] BEEP3_END = 6'd36;

	localparam logic [3:0] BLINK_SET_TH   = 4'd7;
	localparam logic [3:0] BLINK_PAUSE_TH = 4'd5;

	localparam logic [3:0] TPS_RESET = 4'd10;

	localparam logic [3:0] MASK_NONE  = 4'b0000;
	localparam logic [3:0] MASK_END   = 4'b0001;
	localparam logic [3:0] MASK_MIN   = 4'b0011;
	localparam logic [3:0] MASK_SEC   = 4'b1100;
	localparam logic [3:0] MASK_ALL   = 4'b1111;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_UP    = 3'd1,
		CMD_DOWN  = 3'd2,
		CMD_MODE  = 3'd3,
		CMD_START = 3'd4,
		CMD_STOP  = 3'd5,
		CMD_LIGHT = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_SET_MIN = 2'd1,
		MODE_SET_SEC = 2'd2,
		MODE_PAUSED  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [5:0] mn;
		logic [5:0] sc;
		logic [5:0] smn;
		logic [5:0] ssc;
		logic [3:0] sub;
		mode_t      md;
		logic       run;
		logic       act;
		logic       arm;
		logic       lck;
		logic       lamp;
		logic       ltf;
		logic [5:0] fc;
		logic       fin;
		logic       beep;
	} st_t;

	// result beat layout, highest bit first
	typedef struct packed {
		logic [6:0] pad;
		logic       is_counting;
		logic [1:0] view_mode;
		logic       beeper_on;
		logic       lamp_on;
		logic [3:0] blank_mask;
		logic [3:0] sec_ones;
		logic [3:0] sec_tens;
		logic [3:0] min_ones;
		logic [3:0] min_tens;
	} res_t;

endpackage

// ===== rtl/core/exposure_countdown_timer.sv =====
// Exposure countdown timer: event-driven state update and display decode.
// Depends on ect_pkg.
//
// Usage:
//   Input channel s_*: one beat per event. s_tuser[2:0] is the command
//   (tick, up, down, mode, start/pause, stop, light), s_tdata[3:0] the
//   display blink phase. Each accepted beat yields exactly one result beat
//   on m_*: the four digit codes, blank mask, lamp, beeper, view mode and
//   counting flag of the state after that event.
//   cfg_we/cfg_data write ticks_per_second; write only while idle.
//   Latency: the result is on m_* the cycle after the input beat.
//   Throughput: one beat per cycle while results are taken; the state
//   update is a single combinational pass from the state registers into
//   the state and result registers.
//   Stall: while a result waits with m_tready low, s_tready is low; it
//   rises again in the cycle the result is taken, so no bubble appears.
//   Reset: time, saved time, flags and lamp clear, view is normal,
//   ticks_per_second returns to 10, no result is pending.
module exposure_countdown_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] blink_phase, [7:4] zero
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] min_tens, [7:4] min_ones, [11:8] sec_tens, [15:12] sec_ones,
	// [19:16] blank_mask, [20] lamp_on, [21] beeper_on, [23:22] view_mode,
	// [24] is_counting, [31:25] zero
	output logic [31:0] m_tdata
);

	ect_pkg::st_t  st_q, nx;
	ect_pkg::res_t res, res_q;
	logic [3:0]    tps_q;
	logic          m_valid_q;
	logic          s_acc;
	logic [2:0]    cmd;
	logic [3:0]    phase;
	logic [3:0]    dig [4];
	logic [3:0]    mask;

	function automatic logic tzero(input ect_pkg::st_t s);
		return (s.mn == 6'd0) && (s.sc == 6'd0);
	endfunction

	function automatic logic [5:0] wrap_up(input logic [5:0] v);
		return (v < ect_pkg::TIME_MAX) ? 6'(v + 6'd1) : 6'd0;
	endfunction

	function automatic logic [5:0] wrap_down(input logic [5:0] v);
		logic [5:0] r;
		if (v > ect_pkg::TIME_MAX) r = ect_pkg::TIME_MAX;
		else if (v > 6'd0) r = 6'(v - 6'd1);
		else r = ect_pkg::TIME_MAX;
		return r;
	endfunction

	function automatic ect_pkg::st_t service(input ect_pkg::st_t si, input logic tick,
			input logic [3:0] tps);
		ect_pkg::st_t s;
		logic [3:0]   lim;
		s = si;
		lim = (tps == 4'd0) ? 4'd1 : tps;
		if (!tzero(s)) begin
			s.act = 1'b1;
			s.arm = 1'b1;
			if (!s.run) begin
				s.md = ect_pkg::MODE_PAUSED;
				s.lamp = 1'b0;
			end else begin
				s.md = ect_pkg::MODE_NORMAL;
				s.lamp = 1'b1;
				s.lck = 1'b1;
				if (tick) begin
					s.sub = 4'(s.sub + 4'd1);
					if (s.sub >= lim) begin
						if (s.sc > 6'd0) begin
							s.sc = (s.sc > ect_pkg::TIME_MAX) ? ect_pkg::TIME_MAX
								: 6'(s.sc - 6'd1);
						end else begin
							s.sc = ect_pkg::TIME_MAX;
							s.mn = 6'(s.mn - 6'd1);
						end
						s.sub = 4'd0;
					end
					if (tzero(s)) begin
						s.lamp = 1'b0;
						s.fin = 1'b1;
						s.fc = 6'd0;
					end
				end
			end
		end
		return s;
	endfunction

	function automatic ect_pkg::st_t finish_tick(input ect_pkg::st_t si);
		ect_pkg::st_t s;
		logic [5:0]   n;
		s = si;
		n = 6'(s.fc + 6'd1);
		s.fc = n;
		s.beep = (n <= ect_pkg::BEEP1_END)
			|| (n >= ect_pkg::BEEP2_BEG && n <= ect_pkg::BEEP2_END)
			|| (n >= ect_pkg::BEEP3_BEG && n <= ect_pkg::BEEP3_END);
		if (n >= ect_pkg::FINISH_LEN) begin
			s.fin = 1'b0;
			s.fc = 6'd0;
			s.lck = 1'b0;
			s.act = 1'b0;
			s.run = 1'b0;
		end
		return s;
	endfunction

	// tens digit of a value up to 63 by compare chain
	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd60) t = 4'd6;
		else if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [5:0] r;
		r = 6'(v - 6'(tens_of(v)) * 6'd10);
		return r[3:0];
	endfunction

	assign cmd      = s_tuser;
	assign phase    = s_tdata[3:0];
	assign s_tready = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		nx = st_q;
		if (st_q.fin) begin
			if (cmd == ect_pkg::CMD_TICK) nx = finish_tick(nx);
		end else begin
			case (cmd)
				ect_pkg::CMD_UP, ect_pkg::CMD_DOWN: begin
					if (!nx.lck) begin
						if (nx.md == ect_pkg::MODE_SET_MIN)
							nx.mn = (cmd == ect_pkg::CMD_UP) ? wrap_up(nx.mn) : wrap_down(nx.mn);
						else if (nx.md == ect_pkg::MODE_SET_SEC)
							nx.sc = (cmd == ect_pkg::CMD_UP) ? wrap_up(nx.sc) : wrap_down(nx.sc);
						nx.smn = nx.mn;
						nx.ssc = nx.sc;
					end
				end
				ect_pkg::CMD_MODE: begin
					if (!nx.lck) begin
						case (nx.md)
							ect_pkg::MODE_NORMAL:  nx.md = ect_pkg::MODE_SET_MIN;
							ect_pkg::MODE_SET_MIN: nx.md = ect_pkg::MODE_SET_SEC;
							default:               nx.md = ect_pkg::MODE_NORMAL;
						endcase
					end
				end
				ect_pkg::CMD_START: begin
					if (!tzero(nx)) begin
						nx.run = !nx.run;
						nx = service(nx, 1'b0, tps_q);
					end
				end
				ect_pkg::CMD_STOP: begin
					if (nx.arm) begin
						nx.act = 1'b0;
						nx.lamp = 1'b0;
						nx.lck = 1'b0;
						nx.arm = 1'b0;
						nx.run = 1'b0;
						nx.md = ect_pkg::MODE_NORMAL;
						nx.mn = nx.smn;
						nx.sc = nx.ssc;
					end else begin
						nx.mn = 6'd0;
						nx.sc = 6'd0;
					end
				end
				ect_pkg::CMD_LIGHT: begin
					if (!nx.lck) begin
						nx.lamp = !nx.ltf;
						nx.ltf = !nx.ltf;
					end
				end
				default: ;
			endcase
			if (nx.act && !nx.fin) nx = service(nx, cmd == ect_pkg::CMD_TICK, tps_q);
		end
	end

	// display decode of the updated state
	always_comb begin
		if (nx.fin) begin
			dig[0] = 4'd0;
			dig[1] = ect_pkg::END_D1;
			dig[2] = ect_pkg::END_D2;
			dig[3] = ect_pkg::END_D3;
			mask   = ect_pkg::MASK_END;
		end else begin
			if (nx.md == ect_pkg::MODE_SET_MIN && phase > ect_pkg::BLINK_SET_TH)
				mask = ect_pkg::MASK_MIN;
			else if (nx.md == ect_pkg::MODE_SET_SEC && phase > ect_pkg::BLINK_SET_TH)
				mask = ect_pkg::MASK_SEC;
			else if (nx.md == ect_pkg::MODE_PAUSED && phase > ect_pkg::BLINK_PAUSE_TH)
				mask = ect_pkg::MASK_ALL;
			else
				mask = ect_pkg::MASK_NONE;
			dig[0] = mask[0] ? 4'd0 : tens_of(nx.mn);
			dig[1] = mask[1] ? 4'd0 : ones_of(nx.mn);
			dig[2] = mask[2] ? 4'd0 : tens_of(nx.sc);
			dig[3] = mask[3] ? 4'd0 : ones_of(nx.sc);
		end
		res             = '0;
		res.min_tens    = dig[0];
		res.min_ones    = dig[1];
		res.sec_tens    = dig[2];
		res.sec_ones    = dig[3];
		res.blank_mask  = mask;
		res.lamp_on     = nx.lamp;
		res.beeper_on   = nx.beep;
		res.view_mode   = nx.md;
		res.is_counting = nx.run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			tps_q     <= ect_pkg::TPS_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) tps_q <= cfg_data;
			if (s_acc) st_q <= nx;
			if (s_acc) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

endmodule

// ===== rtl/core/ect_checker.sv =====
// Port-level checker for the exposure countdown timer, bound to the top level.
// Depends on ect_pkg and exposure_countdown_timer_assert.svh.
`include "exposure_countdown_timer_assert.svh"

module ect_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result beat holds
	`ECT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// an accepted input beat always leaves a result beat behind
	`ECT_ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid)

	// the end pattern comes with counting on, lamp off and only the minute-tens digit blank
	`ECT_ASSERT_IMPL(a_end_pat, m_tvalid && m_tdata[7:4] == ect_pkg::END_D1,
		m_tdata[24] && !m_tdata[20] && m_tdata[19:16] == ect_pkg::MASK_END
		&& m_tdata[11:8] == ect_pkg::END_D2 && m_tdata[15:12] == ect_pkg::END_D3)

	// beeper sounds only during the end phase
	`ECT_ASSERT_IMPL(a_beep, m_tvalid && m_tdata[21],
		m_tdata[24] && m_tdata[7:4] == ect_pkg::END_D1)

endmodule

bind exposure_countdown_timer ect_checker u_ect_checker (.*);

// ===== tb/tb_exposure_countdown_timer.sv =====
// Self-checking bench for exposure_countdown_timer: drives event beats, predicts every
// display beat in a scoreboard class and compares the result beats field by field.
// Depends on ect_pkg and the timer RTL.
module tb_exposure_countdown_timer;

	localparam int CYCLE_LIMIT = 400000;
	localparam int EVENTS_PER_SETTING = 140;
	localparam int MAX_PRINTS = 200;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	class display_scoreboard;
		bit [3:0] tps;
		bit [5:0] mins, secs, saved_mins, saved_secs, end_cnt;
		bit [3:0] sub_cnt;
		ect_pkg::mode_t mode;
		bit running, active, armed, locked, lamp, lamp_flag, ending, beep;
		ect_pkg::res_t expected_displays[$];
		int errors;
		int events_seen;
		int displays_seen;

		function new();
			tps = ect_pkg::TPS_RESET;
			mode = ect_pkg::MODE_NORMAL;
		endfunction

		task report_mismatch(string what);
			errors++;
			// keep the log bounded when the design is badly off
			if (errors <= MAX_PRINTS)
				$display("mismatch at display beat %0d: %s", displays_seen, what);
		endtask

		function bit [5:0] step_up(bit [5:0] v);
			return (v < ect_pkg::TIME_MAX) ? v + 6'd1 : 6'd0;
		endfunction

		function bit [5:0] step_down(bit [5:0] v);
			if (v > ect_pkg::TIME_MAX)
				return ect_pkg::TIME_MAX;
			return (v > 0) ? v - 6'd1 : ect_pkg::TIME_MAX;
		endfunction

		function bit time_zero();
			return mins == 0 && secs == 0;
		endfunction

		// runs after every event while a countdown is active
		function void run_countdown(bit tick);
			bit [3:0] lim;
			if (time_zero())
				return;
			active = 1'b1;
			armed = 1'b1;
			if (!running) begin
				mode = ect_pkg::MODE_PAUSED;
				lamp = 1'b0;
				return;
			end
			mode = ect_pkg::MODE_NORMAL;
			lamp = 1'b1;
			locked = 1'b1;
			if (tick) begin
				lim = (tps == 0) ? 4'd1 : tps;
				sub_cnt = sub_cnt + 4'd1;
				if (sub_cnt >= lim) begin
					if (secs > 0)
						secs = (secs > ect_pkg::TIME_MAX) ? ect_pkg::TIME_MAX : secs - 6'd1;
					else begin
						secs = ect_pkg::TIME_MAX;
						mins = mins - 6'd1;
					end
					sub_cnt = 4'd0;
				end
				if (time_zero()) begin
					lamp = 1'b0;
					ending = 1'b1;
					end_cnt = 6'd0;
				end
			end
		endfunction

		function void end_tick();
			bit [5:0] n;
			n = end_cnt + 6'd1;
			end_cnt = n;
			beep = (n <= ect_pkg::BEEP1_END)
				|| (n >= ect_pkg::BEEP2_BEG && n <= ect_pkg::BEEP2_END)
				|| (n >= ect_pkg::BEEP3_BEG && n <= ect_pkg::BEEP3_END);
			if (n >= ect_pkg::FINISH_LEN) begin
				ending = 1'b0;
				end_cnt = 6'd0;
				locked = 1'b0;
				active = 1'b0;
				running = 1'b0;
			end
		endfunction

		function void note_event(bit [2:0] cmd, bit [3:0] phase);
			ect_pkg::res_t want;
			if (ending) begin
				if (cmd == ect_pkg::CMD_TICK)
					end_tick();
			end else begin
				case (cmd)
					ect_pkg::CMD_UP, ect_pkg::CMD_DOWN: begin
						if (!locked) begin
							if (mode == ect_pkg::MODE_SET_MIN)
								mins = (cmd == ect_pkg::CMD_UP) ? step_up(mins)
									: step_down(mins);
							else if (mode == ect_pkg::MODE_SET_SEC)
								secs = (cmd == ect_pkg::CMD_UP) ? step_up(secs)
									: step_down(secs);
							saved_mins = mins;
							saved_secs = secs;
						end
					end
					ect_pkg::CMD_MODE: begin
						if (!locked) begin
							case (mode)
								ect_pkg::MODE_NORMAL:  mode = ect_pkg::MODE_SET_MIN;
								ect_pkg::MODE_SET_MIN: mode = ect_pkg::MODE_SET_SEC;
								default:               mode = ect_pkg::MODE_NORMAL;
							endcase
						end
					end
					ect_pkg::CMD_START: begin
						if (!time_zero()) begin
							running = !running;
							run_countdown(1'b0);
						end
					end
					ect_pkg::CMD_STOP: begin
						if (armed) begin
							active = 1'b0;
							lamp = 1'b0;
							locked = 1'b0;
							armed = 1'b0;
							running = 1'b0;
							mode = ect_pkg::MODE_NORMAL;
							mins = saved_mins;
							secs = saved_secs;
						end else begin
							mins = 6'd0;
							secs = 6'd0;
						end
					end
					ect_pkg::CMD_LIGHT: begin
						if (!locked) begin
							lamp = !lamp_flag;
							lamp_flag = !lamp_flag;
						end
					end
					default: ;
				endcase
				if (active && !ending)
					run_countdown(cmd == ect_pkg::CMD_TICK);
			end

			want = '0;
			if (ending) begin
				want.min_ones = ect_pkg::END_D1;
				want.sec_tens = ect_pkg::END_D2;
				want.sec_ones = ect_pkg::END_D3;
				want.blank_mask = ect_pkg::MASK_END;
			end else begin
				want.min_tens = 4'(mins / 10);
				want.min_ones = 4'(mins % 10);
				want.sec_tens = 4'(secs / 10);
				want.sec_ones = 4'(secs % 10);
				if (mode == ect_pkg::MODE_SET_MIN && phase > ect_pkg::BLINK_SET_TH)
					want.blank_mask = ect_pkg::MASK_MIN;
				else if (mode == ect_pkg::MODE_SET_SEC && phase > ect_pkg::BLINK_SET_TH)
					want.blank_mask = ect_pkg::MASK_SEC;
				else if (mode == ect_pkg::MODE_PAUSED && phase > ect_pkg::BLINK_PAUSE_TH)
					want.blank_mask = ect_pkg::MASK_ALL;
				if (want.blank_mask[0]) want.min_tens = 4'd0;
				if (want.blank_mask[1]) want.min_ones = 4'd0;
				if (want.blank_mask[2]) want.sec_tens = 4'd0;
				if (want.blank_mask[3]) want.sec_ones = 4'd0;
			end
			want.lamp_on = lamp;
			want.beeper_on = beep;
			want.view_mode = mode;
			want.is_counting = running;
			expected_displays.push_back(want);
			events_seen++;
		endfunction

		task compare(string field, int got, int want);
			if (got != want)
				report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
		endtask

		task check_display(ect_pkg::res_t got);
			ect_pkg::res_t want;
			displays_seen++;
			if (expected_displays.size() == 0) begin
				report_mismatch("display beat with nothing expected");
				return;
			end
			want = expected_displays.pop_front();
			compare("min_tens", got.min_tens, want.min_tens);
			compare("min_ones", got.min_ones, want.min_ones);
			compare("sec_tens", got.sec_tens, want.sec_tens);
			compare("sec_ones", got.sec_ones, want.sec_ones);
			compare("blank_mask", got.blank_mask, want.blank_mask);
			compare("lamp_on", got.lamp_on, want.lamp_on);
			compare("beeper_on", got.beeper_on, want.beeper_on);
			compare("view_mode", got.view_mode, want.view_mode);
			compare("is_counting", got.is_counting, want.is_counting);
			compare("pad", got.pad, want.pad);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [3:0] blink_phase, [7:4] zero
	logic [2:0]  s_tuser = '0;    // [2:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [3:0] min_tens, [7:4] min_ones, [11:8] sec_tens, [15:12] sec_ones,
	// [19:16] blank_mask, [20] lamp_on, [21] beeper_on, [23:22] view_mode,
	// [24] is_counting, [31:25] zero
	logic [31:0] m_tdata;

	display_scoreboard board = new();
	bit gaps_on = 1'b0;
	int stall_left = 0;
	int cycles = 0;

	exposure_countdown_timer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: check each taken beat, stall in random bursts
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_display(m_tdata);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (arst_n && gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	function automatic logic [3:0] any_phase();
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic send_event(input logic [2:0] cmd, input logic [3:0] phase);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, phase};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_event(cmd, phase);
	endtask

	task automatic write_tps(input logic [3:0] value);
		s_tvalid <= 1'b0;
		while (board.expected_displays.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.tps = value;
	endtask

	task automatic goto_mode(input ect_pkg::mode_t target);
		int k;
		for (k = 0; k < 3 && board.mode != target; k++)
			send_event(ect_pkg::CMD_MODE, any_phase());
	endtask

	// walk minutes or seconds to a target by the shorter way round
	task automatic dial_to(input bit minutes_sel, input bit [5:0] target);
		bit [5:0] cur;
		int fwd;
		int guard;
		guard = 0;
		cur = minutes_sel ? board.mins : board.secs;
		while (cur != target && guard < 70) begin
			guard++;
			fwd = (int'(target) + 60 - int'(cur)) % 60;
			send_event((fwd <= 30) ? ect_pkg::CMD_UP : ect_pkg::CMD_DOWN, any_phase());
			cur = minutes_sel ? board.mins : board.secs;
		end
	endtask

	task automatic random_noise();
		int n;
		n = $urandom_range(3, 12);
		repeat (n) send_event(3'($urandom_range(0, 7)), any_phase());
	endtask

	// one well-formed exposure: settle, set a short time, start, tick to the end
	task automatic run_exposure();
		bit [5:0] want_min, want_sec;
		int guard;
		int r;
		while (board.ending)
			send_event(ect_pkg::CMD_TICK, any_phase());
		if (board.active)
			send_event(ect_pkg::CMD_STOP, any_phase());
		want_min = (board.tps <= 2 && $urandom_range(0, 5) == 0) ? 6'd1 : 6'd0;
		want_sec = (board.tps <= 2) ? 6'($urandom_range(1, 30)) : 6'($urandom_range(1, 4));
		goto_mode(ect_pkg::MODE_SET_MIN);
		dial_to(1'b1, want_min);
		goto_mode(ect_pkg::MODE_SET_SEC);
		dial_to(1'b0, want_sec);
		goto_mode(ect_pkg::MODE_NORMAL);
		if ($urandom_range(0, 2) == 0)
			send_event(ect_pkg::CMD_LIGHT, any_phase());
		send_event(ect_pkg::CMD_START, any_phase());
		guard = 0;
		while ((board.active || board.ending) && guard < 4000) begin
			guard++;
			r = $urandom_range(0, 39);
			if (board.active && !board.running && !board.ending) begin
				// paused: mostly resume, sometimes abort or poke
				if (r < 24)
					send_event(ect_pkg::CMD_START, any_phase());
				else if (r < 28)
					send_event(ect_pkg::CMD_STOP, any_phase());
				else
					send_event(3'($urandom_range(0, 7)), any_phase());
			end else if (r == 0)
				send_event(ect_pkg::CMD_START, any_phase());
			else if (r == 1)
				send_event(3'($urandom_range(1, 7)), any_phase());
			else if (r == 2 && $urandom_range(0, 3) == 0)
				send_event(ect_pkg::CMD_STOP, any_phase());
			else
				send_event(ect_pkg::CMD_TICK, any_phase());
		end
	endtask

	initial begin
		logic [3:0] tps_plan [6];
		int s;
		int mark;
		tps_plan = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd10, 4'd10};
		tps_plan[4] = 4'($urandom_range(3, 14));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle ticks, unused code, empty start/stop, wraps, blink edges,
		// light toggling, lockout, pause/resume and stop with restore
		send_event(ect_pkg::CMD_TICK, 4'd0);
		send_event(CMD_UNUSED, 4'd15);
		send_event(ect_pkg::CMD_START, 4'd0);
		send_event(ect_pkg::CMD_STOP, 4'd0);
		send_event(ect_pkg::CMD_UP, 4'd0);
		send_event(ect_pkg::CMD_MODE, 4'd8);
		send_event(ect_pkg::CMD_DOWN, 4'd7);
		send_event(ect_pkg::CMD_UP, 4'd15);
		send_event(ect_pkg::CMD_MODE, 4'd8);
		send_event(ect_pkg::CMD_DOWN, 4'd9);
		send_event(ect_pkg::CMD_UP, 4'd7);
		send_event(ect_pkg::CMD_UP, 4'd15);
		send_event(ect_pkg::CMD_UP, 4'd0);
		send_event(ect_pkg::CMD_MODE, 4'd15);
		send_event(ect_pkg::CMD_LIGHT, 4'd0);
		send_event(ect_pkg::CMD_LIGHT, 4'd0);
		send_event(ect_pkg::CMD_LIGHT, 4'd0);
		send_event(ect_pkg::CMD_START, 4'd0);
		send_event(ect_pkg::CMD_UP, 4'd0);
		send_event(ect_pkg::CMD_LIGHT, 4'd0);
		send_event(ect_pkg::CMD_START, 4'd6);
		send_event(ect_pkg::CMD_TICK, 4'd5);
		send_event(ect_pkg::CMD_MODE, 4'd15);
		send_event(ect_pkg::CMD_START, 4'd0);
		send_event(ect_pkg::CMD_STOP, 4'd0);

		for (s = 0; s < 6; s++) begin
			write_tps(tps_plan[s]);
			mark = board.events_seen;
			while (board.events_seen - mark < EVENTS_PER_SETTING) begin
				// the last setting runs without any idling
				gaps_on <= (s != 5) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 4) == 0)
					random_noise();
				else
					run_exposure();
			end
		end

		s_tvalid <= 1'b0;
		while (board.expected_displays.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.expected_displays.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ect_pkg.sv
rtl/core/exposure_countdown_timer.sv
rtl/core/ect_checker.sv
tb/tb_exposure_countdown_timer.sv
